### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Holds the default sizes, the field widths, the operation codes, the
// sequencer states and the result type of the shared compare unit.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DefQueueDepth = 16;
  localparam int unsigned DefValueBits  = 32;

  // Fixed widths of the request and result fields.
  localparam int unsigned KindW     = 2;
  localparam int unsigned InValueW  = 32;
  localparam int unsigned PositionW = 4;
  localparam int unsigned HeadW     = 32;
  localparam int unsigned CountW    = 5;

  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_EV   = 5'b00100,
    ST_PUT  = 5'b01000,
    ST_WB   = 5'b10000
  } state_e;

  typedef struct packed {
    logic less;
    logic equal;
  } cmp_t;

endpackage

### rtl/spq_cmp.sv
// ----------------------------------------------------------------------------
// spq_cmp: shared signed compare unit
// Compares one stored entry against the request value, giving both the
// signed less-than and the equality result.
// ----------------------------------------------------------------------------
module spq_cmp import spq_pkg::*; #(
  parameter int unsigned ValueBits = DefValueBits
) (
  input  logic [ValueBits-1:0] entry_i,
  input  logic [ValueBits-1:0] value_i,
  output cmp_t                 cmp_o
);

  assign cmp_o.less  = $signed(entry_i) < $signed(value_i);
  assign cmp_o.equal = entry_i == value_i;

endmodule

### rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: bounded priority queue kept in descending order
// Entries live in a single-port-write, registered-read memory and are visited
// one at a time by a small sequencer with one shared compare unit.
// ----------------------------------------------------------------------------
// The queue handles one request at a time and stalls its input until the
// result has been placed in the output register. Every visited entry takes
// a read state and then a compare-and-move state, because the entry memory
// has one registered read port and one write port. An insert into a
// non-empty queue scans from the tail toward the head and also reads the
// entry that stops it; a remove or find scans from the head, and a remove
// always scans to the tail. A status query, a dropped insert, or a remove
// or find on an empty queue goes straight to write-back without a scan. A
// stalled reply holds the unit in write-back. No clearing pass is needed
// after reset.
module sorted_priority_queue_unit import spq_pkg::*; #(
  parameter int unsigned QueueDepth = DefQueueDepth,
  parameter int unsigned ValueBits  = DefValueBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [KindW-1:0]     kind_i,
  input  logic signed [InValueW-1:0] value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 done_ok_o,
  output logic [PositionW-1:0] position_o,
  output logic                 overflow_o,
  output logic signed [HeadW-1:0] head_value_o,
  output logic                 head_valid_o,
  output logic [CountW-1:0]    entry_count_o
);

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [ValueBits-1:0] mem [QueueDepth];

  state_e               state_q, state_d;
  kind_e                kind_q, kind_d;
  logic [ValueBits-1:0] val_q, val_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [IdxW-1:0]      pos_q, pos_d;
  logic                 found_q, found_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [ValueBits-1:0] head_q, head_d;
  logic [ValueBits-1:0] rd_data_q;

  logic                 out_valid_q, out_valid_d;
  logic                 out_done_q;
  logic [PositionW-1:0] out_pos_q;
  logic                 out_ovf_q;
  logic [HeadW-1:0]     out_head_q;
  logic                 out_hvalid_q;
  logic [CountW-1:0]    out_count_q;

  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  logic [ValueBits-1:0] wr_data;
  logic                 load_out;
  logic                 in_accept;
  logic                 is_last;
  logic [IdxW-1:0]      last_idx;
  cmp_t                 cmp;

  logic [ValueBits+InValueW-1:0] in_val_ext;
  logic [IdxW+PositionW-1:0]     pos_ext;
  logic [ValueBits+HeadW-1:0]    head_ext;
  logic [CntW+CountW-1:0]        cnt_ext;

  spq_cmp #(
    .ValueBits(ValueBits)
  ) u_cmp (
    .entry_i(rd_data_q),
    .value_i(val_q),
    .cmp_o  (cmp)
  );

  assign in_stall_o = state_q != ST_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_val_ext = {{ValueBits{1'b0}}, value_i};
  assign last_idx   = IdxW'(count_q - CntW'(1));
  assign is_last    = idx_q == last_idx;
  assign load_out   = (state_q == ST_WB) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    val_d   = val_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    found_d = found_q;
    count_d = count_q;
    head_d  = head_q;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = rd_data_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          kind_d  = kind_e'(kind_i);
          val_d   = in_val_ext[ValueBits-1:0];
          found_d = 1'b0;
          pos_d   = '0;
          case (kind_e'(kind_i))
            KIND_INSERT: begin
              if (count_q == CntW'(QueueDepth)) begin
                state_d = ST_WB;
              end else if (count_q == '0) begin
                state_d = ST_PUT;
              end else begin
                idx_d   = last_idx;
                state_d = ST_RD;
              end
            end
            KIND_REMOVE, KIND_FIND: begin
              idx_d   = '0;
              state_d = (count_q == '0) ? ST_WB : ST_RD;
            end
            default: state_d = ST_WB;
          endcase
        end
      end
      ST_RD: state_d = ST_EV;
      ST_EV: begin
        if (kind_q == KIND_INSERT) begin
          // Walk from the tail toward the head, moving smaller entries down.
          if (cmp.less) begin
            wr_en   = 1'b1;
            wr_addr = idx_q + IdxW'(1);
            if (idx_q == '0) begin
              pos_d   = '0;
              state_d = ST_PUT;
            end else begin
              idx_d   = idx_q - IdxW'(1);
              state_d = ST_RD;
            end
          end else begin
            pos_d   = idx_q + IdxW'(1);
            state_d = ST_PUT;
          end
        end else if (!found_q) begin
          if (cmp.equal) begin
            found_d = 1'b1;
            pos_d   = idx_q;
          end
          if ((cmp.equal && kind_q == KIND_FIND) || is_last) begin
            if (cmp.equal && kind_q == KIND_REMOVE) begin
              count_d = count_q - CntW'(1);
            end
            state_d = ST_WB;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = ST_RD;
          end
        end else begin
          // Past the removed entry: every following entry moves up by one.
          wr_en   = 1'b1;
          wr_addr = idx_q - IdxW'(1);
          if (idx_q == IdxW'(1)) begin
            head_d = rd_data_q;
          end
          if (is_last) begin
            count_d = count_q - CntW'(1);
            state_d = ST_WB;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = ST_RD;
          end
        end
      end
      ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        wr_data = val_q;
        if (pos_q == '0) begin
          head_d = val_q;
        end
        count_d = count_q + CntW'(1);
        found_d = 1'b1;
        state_d = ST_WB;
      end
      ST_WB: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign pos_ext  = {{PositionW{1'b0}}, (found_q ? pos_q : {IdxW{1'b0}})};
  assign head_ext = {{HeadW{1'b0}}, (count_q != '0 ? head_q : {ValueBits{1'b0}})};
  assign cnt_ext  = {{CountW{1'b0}}, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    val_q   <= val_d;
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    found_q <= found_d;
    head_q  <= head_d;
    if (load_out) begin
      out_done_q   <= found_q;
      out_pos_q    <= pos_ext[PositionW-1:0];
      out_ovf_q    <= (kind_q == KIND_INSERT) && !found_q;
      out_head_q   <= head_ext[HeadW-1:0];
      out_hvalid_q <= count_q != '0;
      out_count_q  <= cnt_ext[CountW-1:0];
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state_q == ST_RD) begin
      rd_data_q <= mem[idx_q];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign done_ok_o     = out_done_q;
  assign position_o    = out_pos_q;
  assign overflow_o    = out_ovf_q;
  assign head_value_o  = out_head_q;
  assign head_valid_o  = out_hvalid_q;
  assign entry_count_o = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("entry count exceeds the queue depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CntW'(1)) ||
    (count_q + CntW'(1) == $past(count_q)))
    else $error("entry count moved by more than one");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && kind_i == KIND_INSERT && count_q == CntW'(QueueDepth))
    |=> (state_q == ST_WB && count_q == $past(count_q)))
    else $error("insert into a full queue was not dropped");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EV) |-> (CntW'(idx_q) < count_q))
    else $error("scan index beyond the stored entries");

  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(done_ok_o && overflow_o))
    else $error("result flags both success and overflow");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted priority queue unit
// Sends insert, remove, find and status requests, keeps its own sorted copy
// of the queue to predict every reply, and compares each reply field by field
// while both the request and the reply side pause at random.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 60;
  localparam logic signed [InValueW-1:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [InValueW-1:0] ValMin = 32'sh8000_0000;

  typedef struct packed {
    logic                        done_ok;
    logic [PositionW-1:0]        position;
    logic                        overflow;
    logic signed [HeadW-1:0]     head_value;
    logic                        head_valid;
    logic [CountW-1:0]           entry_count;
  } reply_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [KindW-1:0]              kind_i;
  logic signed [InValueW-1:0]    value_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic                          done_ok_o;
  logic [PositionW-1:0]          position_o;
  logic                          overflow_o;
  logic signed [HeadW-1:0]       head_value_o;
  logic                          head_valid_o;
  logic [CountW-1:0]             entry_count_o;

  // Shadow copy of the queue contents, largest value first.
  logic signed [InValueW-1:0]    shadow_vals [DefQueueDepth];
  int                            shadow_count;

  reply_t                        predicted_replies[$];
  int                            mismatch_count;
  int                            reply_index;
  int                            reply_hold;
  int                            cycle_count;
  bit                            steady;

  sorted_priority_queue_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .done_ok_o     (done_ok_o),
    .position_o    (position_o),
    .overflow_o    (overflow_o),
    .head_value_o  (head_value_o),
    .head_valid_o  (head_valid_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one request to the shadow queue and returns the reply it must give.
  function automatic reply_t sorted_queue_step(input kind_e op,
                                               input logic signed [InValueW-1:0] v);
    reply_t r;
    int     idx;
    r   = '0;
    idx = 0;
    case (op)
      KIND_INSERT: begin
        if (shadow_count >= DefQueueDepth) begin
          r.overflow = 1'b1;
        end else begin
          // Equal values stay behind the ones already stored.
          while (idx < shadow_count && !(shadow_vals[idx] < v)) idx++;
          for (int j = shadow_count; j > idx; j--) shadow_vals[j] = shadow_vals[j-1];
          shadow_vals[idx] = v;
          shadow_count++;
          r.done_ok  = 1'b1;
          r.position = idx[PositionW-1:0];
        end
      end
      KIND_REMOVE, KIND_FIND: begin
        while (idx < shadow_count && shadow_vals[idx] != v) idx++;
        if (idx < shadow_count) begin
          r.done_ok  = 1'b1;
          r.position = idx[PositionW-1:0];
          if (op == KIND_REMOVE) begin
            for (int j = idx; j + 1 < shadow_count; j++) shadow_vals[j] = shadow_vals[j+1];
            shadow_count--;
          end
        end
      end
      default: begin
      end
    endcase
    r.head_valid  = (shadow_count > 0);
    r.head_value  = (shadow_count > 0) ? shadow_vals[0] : '0;
    r.entry_count = shadow_count[CountW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("reply %0d: %s", reply_index, msg);
  endtask

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic issue_request(input kind_e op, input logic signed [InValueW-1:0] v);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= op;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted_replies.push_back(sorted_queue_step(op, v));
  endtask

  // Mostly values already stored or small ones, so removes and finds hit.
  function automatic logic signed [InValueW-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4 && shadow_count > 0) return shadow_vals[$urandom_range(0, shadow_count - 1)];
    if (sel < 7) return int'($urandom_range(0, 15)) - 8;
    if (sel < 9) return $urandom();
    case ($urandom_range(0, 3))
      0:       return ValMax;
      1:       return ValMin;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic test_empty_queue();
    issue_request(KIND_STATUS, '0);
    issue_request(KIND_REMOVE, 32'sd5);
    issue_request(KIND_FIND, '0);
  endtask

  task automatic test_extreme_values();
    issue_request(KIND_INSERT, ValMax);
    issue_request(KIND_INSERT, ValMin);
    issue_request(KIND_INSERT, '0);
    issue_request(KIND_INSERT, '0);
    issue_request(KIND_INSERT, '1);
    issue_request(KIND_FIND, ValMin);
    issue_request(KIND_FIND, 32'sd7);
    issue_request(KIND_REMOVE, '0);
    issue_request(KIND_STATUS, ValMax);
  endtask

  // Back-to-back requests until the queue is full, then one that must drop, then a find and a remove.
  task automatic test_fill_to_overflow();
    steady = 1'b1;
    while (shadow_count < DefQueueDepth) issue_request(KIND_INSERT, $urandom());
    issue_request(KIND_INSERT, 32'sd5);
    issue_request(KIND_FIND, ValMin);
    issue_request(KIND_REMOVE, ValMax);
    steady = 1'b0;
  endtask

  // Phases alternate between filling, draining and a balanced mix.
  task automatic test_random_mix();
    int    ins_pct;
    int    roll;
    kind_e op;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0:       ins_pct = 85;
        1:       ins_pct = 20;
        default: ins_pct = $urandom_range(35, 65);
      endcase
      steady = (phase % 3 == 2);
      for (int n = 0; n < 120; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
          op = KIND_INSERT;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: op = KIND_REMOVE;
            5, 6, 7, 8:    op = KIND_FIND;
            default:       op = KIND_STATUS;
          endcase
        end
        issue_request(op, pick_value());
      end
    end
    steady = 1'b0;
  endtask

  // Reply side: check each accepted reply, then hold off the next one a while.
  always @(posedge clk_i) begin
    reply_t want;
    if (out_valid_o && !out_stall_i) begin
      if (predicted_replies.size() == 0) begin
        report_mismatch("reply with no request outstanding");
      end else begin
        want = predicted_replies.pop_front();
        if (done_ok_o !== want.done_ok)
          report_mismatch($sformatf("done_ok got %0d, expected %0d", done_ok_o, want.done_ok));
        if (position_o !== want.position)
          report_mismatch($sformatf("position got %0d, expected %0d",
                                    position_o, want.position));
        if (overflow_o !== want.overflow)
          report_mismatch($sformatf("overflow got %0d, expected %0d",
                                    overflow_o, want.overflow));
        if (head_value_o !== want.head_value)
          report_mismatch($sformatf("head_value got %0d, expected %0d",
                                    head_value_o, want.head_value));
        if (head_valid_o !== want.head_valid)
          report_mismatch($sformatf("head_valid got %0d, expected %0d",
                                    head_valid_o, want.head_valid));
        if (entry_count_o !== want.entry_count)
          report_mismatch($sformatf("entry_count got %0d, expected %0d",
                                    entry_count_o, want.entry_count));
      end
      reply_index++;
      reply_hold = steady ? 0 : $urandom_range(0, 13);
    end else if (reply_hold > 0 && (out_valid_o || $urandom_range(0, 1) == 0)) begin
      reply_hold--;
    end
    out_stall_i <= (reply_hold != 0);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL sorted_priority_queue_unit");
    $finish;
  end

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    kind_i         <= KIND_STATUS;
    value_i        <= '0;
    out_stall_i    <= 1'b0;
    shadow_count   = 0;
    mismatch_count = 0;
    reply_index    = 0;
    reply_hold     = 0;
    steady         = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_extreme_values();
    test_fill_to_overflow();
    test_random_mix();

    in_valid_i <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && predicted_replies.size() == 0) begin
      $display("PASS sorted_priority_queue_unit");
    end else begin
      $display("FAIL sorted_priority_queue_unit");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/spq_pkg.sv
rtl/spq_cmp.sv
rtl/sorted_priority_queue_unit.sv
verif/tb.sv
